FILE: rtl/plut_pkg.sv
`default_nettype none

package plut_pkg;

    localparam int DATA_W    = 32;
    localparam int PIU_W     = 7;
    localparam int SLOT_IN_W = 6;
    localparam int STATUS_W  = 2;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = 5;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_EVAL  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_IN_RANGE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BELOW    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/piecewise_linear_lookup.sv
// write item: taken in the idle state, the next item can follow in the next cycle
// evaluate item: a below or above result after the search, an interpolated result after
// the search, two breakpoint fetches and the divider; search probes <= ceil(log2(n + 1))
// the probe loop reads the breakpoint memories through one read port; the divider is 32-step shift-add
// input stalls until the current evaluate has its result in the output register
// reset clears the fsm, the output valid and points_in_use; breakpoint memories are not cleared
`default_nettype none

module piecewise_linear_lookup #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   action,
    input  wire logic        [plut_pkg::SLOT_IN_W-1:0]  point_index,
    input  wire logic signed [plut_pkg::DATA_W-1:0]     point_x,
    input  wire logic signed [plut_pkg::DATA_W-1:0]     point_y,
    input  wire logic signed [plut_pkg::DATA_W-1:0]     query_x,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed      [plut_pkg::DATA_W-1:0]     interpolated_value,
    output logic             [plut_pkg::STATUS_W-1:0]   range_status,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [plut_pkg::PIU_W-1:0]      cfg_data
);

    import plut_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int N_W    = (CNT_W > PIU_W) ? CNT_W : PIU_W;
    localparam int SLOT_W = ((IDX_W > SLOT_IN_W) ? IDX_W : SLOT_IN_W) + 1;

    logic [DATA_W-1:0] bp_x_mem [MAX_POINTS];
    logic [DATA_W-1:0] bp_y_mem [MAX_POINTS];
    logic [DATA_W-1:0] rd_x_reg;
    logic [DATA_W-1:0] rd_y_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;

    state_t state_reg, state_next;
    logic [PIU_W-1:0] points_in_use_reg;

    logic signed [DATA_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [DATA_W-1:0]        x0_reg, x0_next;
    logic [DATA_W-1:0]        y0_reg, y0_next;
    logic [DATA_W-1:0]        dx_reg, dx_next;
    logic [DATA_W-1:0]        t_reg, t_next;
    logic [DATA_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        quo_reg, quo_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_value_reg, out_value_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;

    logic              in_accept;
    logic              out_free;
    logic [N_W-1:0]    piu_ext;
    logic [N_W-1:0]    n_full;
    logic [CNT_W-1:0]  n_clip;
    logic [SLOT_W-1:0] slot_ext;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  lo_m1;
    logic [DATA_W:0]   dx_full;
    logic [DATA_W:0]   dy_full;
    logic [DATA_W:0]   dy_abs;
    logic [DATA_W:0]   t_full;
    logic [DATA_W+1:0] step_sum;
    logic [DATA_W+1:0] dx_one;
    logic [DATA_W+1:0] dx_two;
    logic [DATA_W-1:0] interp;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid          = out_valid_reg;
    assign interpolated_value = out_value_reg;
    assign range_status       = out_status_reg;

    assign piu_ext  = N_W'(points_in_use_reg);
    assign n_full   = (piu_ext > N_W'(MAX_POINTS)) ? N_W'(MAX_POINTS) : piu_ext;
    assign n_clip   = n_full[CNT_W-1:0];
    assign slot_ext = SLOT_W'(point_index);
    assign wr_addr  = slot_ext[IDX_W-1:0];
    assign wr_en    = in_accept && (action == ACTION_WRITE)
                      && (slot_ext < SLOT_W'(MAX_POINTS));

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - CNT_W'(1);

    assign dx_full = {rd_x_reg[DATA_W-1], rd_x_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dy_full = {rd_y_reg[DATA_W-1], rd_y_reg} - {y0_reg[DATA_W-1], y0_reg};
    assign dy_abs  = dy_full[DATA_W] ? (~dy_full + 1'b1) : dy_full;
    assign t_full  = {q_reg[DATA_W-1], q_reg} - {x0_reg[DATA_W-1], x0_reg};

    assign step_sum = {1'b0, rem_reg, 1'b0} + {2'b00, (mag_reg[DATA_W-1] ? t_reg : '0)};
    assign dx_one   = {2'b00, dx_reg};
    assign dx_two   = {1'b0, dx_reg, 1'b0};
    assign interp   = neg_reg ? (y0_reg - quo_reg) : (y0_reg + quo_reg);

    // breakpoint memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bp_x_mem[wr_addr] <= point_x;
            bp_y_mem[wr_addr] <= point_y;
        end
        rd_x_reg <= bp_x_mem[rd_addr];
        rd_y_reg <= bp_y_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            points_in_use_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                points_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        n_reg          <= n_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        dx_reg         <= dx_next;
        t_reg          <= t_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == ACTION_EVAL))
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_COMPARE;
                end
                else if ((lo_reg == '0) || (lo_reg == n_reg))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_FETCH_LO;
                end
            end
            ST_COMPARE:  state_next = ST_SEARCH;
            ST_FETCH_LO: state_next = ST_FETCH_HI;
            ST_FETCH_HI: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rd_addr         = '0;
        q_next          = q_reg;
        n_next          = n_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        dx_next         = dx_reg;
        t_next          = t_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == ACTION_EVAL))
                begin
                    q_next  = query_x;
                    n_next  = n_clip;
                    lo_next = '0;
                    hi_next = n_clip;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr  = mid[IDX_W-1:0];
                    mid_next = mid;
                end
                else if (lo_reg == '0)
                begin
                    status_next = STATUS_BELOW;
                end
                else if (lo_reg == n_reg)
                begin
                    status_next = STATUS_ABOVE;
                end
                else
                begin
                    rd_addr     = lo_m1[IDX_W-1:0];
                    status_next = STATUS_IN_RANGE;
                end
            end
            ST_COMPARE:
            begin
                if ($signed(rd_x_reg) > q_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
            end
            ST_FETCH_LO:
            begin
                x0_next = rd_x_reg;
                y0_next = rd_y_reg;
                rd_addr = lo_reg[IDX_W-1:0];
            end
            ST_FETCH_HI:
            begin
                dx_next  = dx_full[DATA_W-1:0];
                t_next   = t_full[DATA_W-1:0];
                mag_next = dy_abs[DATA_W-1:0];
                neg_next = dy_full[DATA_W];
                quo_next = '0;
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIVIDE:
            begin
                // remainder stays below dx, so at most two subtractions per step
                if (step_sum >= dx_two)
                begin
                    rem_next = DATA_W'(step_sum - dx_two);
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0} + DATA_W'(2);
                end
                else if (step_sum >= dx_one)
                begin
                    rem_next = DATA_W'(step_sum - dx_one);
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = step_sum[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                mag_next = {mag_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = (status_reg == STATUS_IN_RANGE) ? interp : '0;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/plut_checker.sv
`default_nettype none

module plut_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                action,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [plut_pkg::DATA_W-1:0]  interpolated_value,
    input wire logic        [plut_pkg::STATUS_W-1:0] range_status
);

    import plut_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(interpolated_value)
                                   && $stable(range_status))
        else $error("stalled result changed");

    // out of range results carry a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (range_status != STATUS_IN_RANGE) |-> interpolated_value == '0)
        else $error("nonzero value with out of range status");

    // a write transfer leaves the input open
    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACTION_WRITE) |=> !in_stall)
        else $error("input stalled after write");

    // an evaluate transfer holds off the next item
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACTION_EVAL) |=> in_stall)
        else $error("input open right after evaluate");

endmodule

bind piecewise_linear_lookup plut_checker u_plut_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plut_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_GAP     = 4;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 50;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam longint FULL_RANGE = 64'sd4294967296;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
    } lookup_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        action;
    logic        [SLOT_IN_W-1:0] point_index;
    logic signed [DATA_W-1:0]    point_x;
    logic signed [DATA_W-1:0]    point_y;
    logic signed [DATA_W-1:0]    query_x;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    interpolated_value;
    logic        [STATUS_W-1:0]  range_status;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic        [PIU_W-1:0]     cfg_data;

    // predictor copy of the table and the point count
    logic signed [DATA_W-1:0] table_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0] table_y [TABLE_DEPTH];
    logic        [PIU_W-1:0]  point_count;

    lookup_result_t pending_results [$];
    lookup_result_t head_result;

    int items_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int cfg_writes      = 0;
    int in_range_seen   = 0;
    int below_seen      = 0;
    int above_seen      = 0;
    int idle_cycles     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    piecewise_linear_lookup #(
        .MAX_POINTS(TABLE_DEPTH)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .point_index        (point_index),
        .point_x            (point_x),
        .point_y            (point_y),
        .query_x            (query_x),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .interpolated_value (interpolated_value),
        .range_status       (range_status),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic lookup_result_t lookup_interpolate(input logic signed [DATA_W-1:0] q);
        lookup_result_t   res;
        int               n;
        int               lo;
        int               hi;
        int               mid;
        longint           x0;
        longint           y0;
        longint           x1;
        longint           y1;
        longint           dy;
        longint           t;
        longint           dx;
        longint           r;
        longint unsigned  mag;
        longint unsigned  quot;
        n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_x[mid] > q)
                hi = mid;
            else
                lo = mid + 1;
        end
        res.value = '0;
        if (lo == 0)
            res.status = STATUS_BELOW;
        else if (lo >= n)
            res.status = STATUS_ABOVE;
        else
        begin
            res.status = STATUS_IN_RANGE;
            x0 = table_x[lo-1];
            y0 = table_y[lo-1];
            x1 = table_x[lo];
            y1 = table_y[lo];
            dy = y1 - y0;
            t  = q - x0;
            dx = x1 - x0;
            if (dx <= 0 || t < 0 || t >= dx)
                r = y0;
            else
            begin
                mag  = (dy < 0) ? -dy : dy;
                quot = (mag * t) / dx;
                r    = (dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot);
            end
            res.value = r[DATA_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch in %s: expected %h, got %h", $time, what, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", '0, interpolated_value);
            else
            begin
                head_result = pending_results.pop_front();
                results_checked++;
                if (range_status !== head_result.status)
                    report_mismatch("range_status", DATA_W'(head_result.status),
                                    DATA_W'(range_status));
                if (interpolated_value !== head_result.value)
                    report_mismatch("interpolated_value", head_result.value,
                                    interpolated_value);
                case (head_result.status)
                    STATUS_IN_RANGE: in_range_seen++;
                    STATUS_BELOW:    below_seen++;
                    default:         above_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic issue_item(input logic act, input logic [SLOT_IN_W-1:0] slot,
                              input logic signed [DATA_W-1:0] px,
                              input logic signed [DATA_W-1:0] py,
                              input logic signed [DATA_W-1:0] qx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        point_index <= slot;
        point_x     <= px;
        point_y     <= py;
        query_x     <= qx;
        do @(posedge clk); while (in_stall);
        if (act == ACTION_WRITE)
        begin
            table_x[slot] = px;
            table_y[slot] = py;
        end
        else
            pending_results.push_back(lookup_interpolate(qx));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic put_breakpoint(input int slot, input logic signed [DATA_W-1:0] px,
                                  input logic signed [DATA_W-1:0] py);
        issue_item(ACTION_WRITE, SLOT_IN_W'(slot), px, py, $urandom);
    endtask

    task automatic evaluate_at(input logic signed [DATA_W-1:0] q);
        issue_item(ACTION_EVAL, SLOT_IN_W'($urandom), $urandom, $urandom, q);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_point_count(input int cnt);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= PIU_W'(cnt);
        do @(posedge clk); while (!cfg_ready);
        point_count = PIU_W'(cnt);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_table();
        evaluate_at(32'sd0);
        evaluate_at(Q_MAX);
        evaluate_at(Q_MIN);
    endtask

    task automatic test_single_point();
        put_breakpoint(0, 32'sh000a_0000, 32'sh0003_8000);
        write_point_count(1);
        evaluate_at(32'sh0009_ffff);
        evaluate_at(32'sh000a_0000);
        evaluate_at(Q_MIN);
        evaluate_at(Q_MAX);
    endtask

    task automatic test_edge_breakpoints();
        put_breakpoint(0, Q_MIN, Q_MIN);
        put_breakpoint(1, 32'sd0, Q_MAX);
        put_breakpoint(2, Q_MAX, Q_MIN);
        write_point_count(3);
        evaluate_at(Q_MIN);
        evaluate_at(-32'sd1);
        evaluate_at(32'sd0);
        evaluate_at(Q_MAX - 32'sd1);
        evaluate_at(Q_MAX);
    endtask

    // flat segment and an out-of-order last point
    task automatic test_unsorted_table();
        put_breakpoint(2, 32'sh0001_0000, Q_MAX);
        put_breakpoint(3, -32'sd5, 32'sh1234_0000);
        write_point_count(4);
        evaluate_at(32'sd100);
        evaluate_at(-32'sd3);
        evaluate_at(32'sh0002_0000);
    endtask

    task automatic test_random_tables(input int phase_id, input int budget);
        int                       first_item;
        int                       seg;
        int                       m;
        int                       n;
        int                       r;
        int                       i;
        int                       j;
        int                       tmp;
        int                       evals;
        int                       order [TABLE_DEPTH];
        longint                   gap_max;
        longint                   span;
        longint                   base;
        longint                   lv;
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] seg_x [TABLE_DEPTH];
        logic signed [DATA_W-1:0] seg_y [TABLE_DEPTH];
        first_item = items_sent;
        seg = 0;
        while (items_sent - first_item < budget)
        begin
            if (seg == 0)
            begin
                m = TABLE_DEPTH;
                n = (phase_id == 0) ? TABLE_DEPTH
                  : (phase_id == 1) ? 127 : $urandom_range(TABLE_DEPTH + 1, 127);
            end
            else
            begin
                r = $urandom_range(0, 15);
                if (r == 0)
                begin
                    m = 0;
                    n = 0;
                end
                else if (r == 1)
                begin
                    m = 1;
                    n = 1;
                end
                else if (r == 2)
                begin
                    m = TABLE_DEPTH;
                    n = $urandom_range(TABLE_DEPTH, 127);
                end
                else
                begin
                    m = $urandom_range(2, 12);
                    n = m;
                end
            end

            // strictly increasing x, wide or narrow spacing
            if ($urandom_range(0, 1) == 1)
                gap_max = 64'd67108863;
            else
                gap_max = $urandom_range(1, 4096);
            span = (m > 1) ? gap_max * (m - 1) : 0;
            lv = $urandom;
            if ($urandom_range(0, 7) == 0)
                base = Q_MIN;
            else
                base = longint'(Q_MIN) + (lv % (FULL_RANGE - span));
            lv = base;
            for (i = 0; i < m; i++)
            begin
                if (i > 0)
                    lv = lv + $urandom_range(1, int'(gap_max));
                seg_x[i] = lv[DATA_W-1:0];
                if (i > 0 && $urandom_range(0, 7) == 0)
                    seg_y[i] = seg_y[i-1];
                else
                    seg_y[i] = $urandom;
                order[i] = i;
            end
            for (i = m - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < m; i++)
                put_breakpoint(order[i], seg_x[order[i]], seg_y[order[i]]);
            write_point_count(n);

            evals = $urandom_range(8, 24);
            repeat (evals)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    wait_drained();
                if (r < 10)
                begin
                    if (m > 0 && r < 7)
                    begin
                        j = $urandom_range(0, m - 1);
                        seg_y[j] = $urandom;
                        put_breakpoint(j, seg_x[j], seg_y[j]);
                    end
                    else
                        put_breakpoint($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
                end
                r = $urandom_range(0, 99);
                if (m < 2 || r < 25)
                    q = $urandom;
                else if (r < 70)
                begin
                    i = $urandom_range(0, m - 2);
                    lv = longint'(seg_x[i+1]) - longint'(seg_x[i]);
                    q = DATA_W'(longint'(seg_x[i]) + ({32'd0, $urandom} % lv));
                end
                else if (r < 82)
                    q = seg_x[$urandom_range(0, m - 1)];
                else if (r < 91)
                    q = seg_x[0] - 32'sd1;
                else
                    q = seg_x[m-1];
                evaluate_at(q);
            end
            seg++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACTION_WRITE;
        point_index = '0;
        point_x     = '0;
        point_y     = '0;
        query_x     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        point_count = '0;
        send_idle_pct  = 7;
        recv_stall_pct = 72;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_single_point();
        test_edge_breakpoints();
        test_unsorted_table();

        send_idle_pct  = 7;
        recv_stall_pct = 72;
        test_random_tables(0, 311);
        send_idle_pct  = 72;
        recv_stall_pct = 7;
        test_random_tables(1, 311);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_tables(2, 311);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d input transfers and %0d point-count writes, %0d results checked",
                 items_sent, cfg_writes, results_checked);
        $display("results: %0d interpolated, %0d below first point, %0d at or past last point",
                 in_range_seen, below_seen, above_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/plut_pkg.sv
rtl/piecewise_linear_lookup.sv
rtl/plut_checker.sv
verif/tb_top.sv
